@@ rtl/bmq_pkg.sv @@
// Shared types, codes and widths for the blocking message queue.
// No dependencies; every other file of the block but bmq_ram imports this package.
package bmq_pkg;

   // Fixed field widths of the request, response and register channels
   localparam int TASK_W      = 8;
   localparam int MSG_PORT_W  = 32;
   localparam int KIND_W      = 3;
   localparam int CAP_W       = 5;

   // Capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // Defaults for the top-level parameters
   localparam int DEF_QUEUE_DEPTH  = 16;
   localparam int DEF_WAITER_DEPTH = 8;
   localparam int DEF_MESSAGE_BITS = 32;

   typedef enum logic {
      OP_SEND    = 1'b0,
      OP_RECEIVE = 1'b1
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_STORED    = 3'd0,
      KIND_DELIVERED = 3'd1,
      KIND_BLOCKED   = 3'd2,
      KIND_WOKEN     = 3'd3,
      KIND_REJECTED  = 3'd4
   } result_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SECOND
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic capture;
      logic commit;
      logic load_second;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic out_free;
      logic two_results;
   } status_type;

endpackage

@@ rtl/bmq_req_if.sv @@
// Request channel of the blocking message queue: valid/ready plus one request.
// Depends on bmq_pkg.
interface bmq_req_if import bmq_pkg::*; ();
   logic               valid;
   logic               ready;
   op_type             operation;
   logic [TASK_W-1:0]  task_id;
   logic [MSG_PORT_W-1:0] message;

   modport source (output valid, operation, task_id, message, input ready);
   modport sink   (input valid, operation, task_id, message, output ready);
endinterface

@@ rtl/bmq_rsp_if.sv @@
// Response channel of the blocking message queue: valid/ready plus one result.
// Depends on bmq_pkg.
interface bmq_rsp_if import bmq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   result_kind_type       result_kind;
   logic [TASK_W-1:0]     result_task;
   logic [MSG_PORT_W-1:0] result_message;
   logic                  last_result;

   modport source (output valid, result_kind, result_task, result_message, last_result,
                   input ready);
   modport sink   (input valid, result_kind, result_task, result_message, last_result,
                   output ready);
endinterface

@@ rtl/bmq_csr_if.sv @@
// Register write channel of the blocking message queue: valid/ready plus capacity.
// Depends on bmq_pkg.
interface bmq_csr_if import bmq_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] queue_capacity;

   modport source (output valid, queue_capacity, input ready);
   modport sink   (input valid, queue_capacity, output ready);
endinterface

@@ rtl/bmq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bmq_ctrl.sv @@
// Controller of the blocking message queue: sequences accept, execute and
// second-result steps. Depends on bmq_pkg.
module bmq_ctrl import bmq_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (status.out_free) state_in = status.two_results ? ST_SECOND : ST_IDLE;
         end
         ST_SECOND: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      req_ready       = 1'b0;
      cmd.capture     = 1'b0;
      cmd.commit      = 1'b0;
      cmd.load_second = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_EXEC: begin
            cmd.commit = status.out_free;
         end
         ST_SECOND: begin
            cmd.load_second = status.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/bmq_datapath.sv @@
// Datapath of the blocking message queue: ring, waiter stacks, counters,
// capacity register and response register. Depends on bmq_pkg and bmq_ram.
module bmq_datapath import bmq_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int WAITER_DEPTH = DEF_WAITER_DEPTH,
   parameter int MESSAGE_BITS = DEF_MESSAGE_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   // request payload
   input  op_type                req_operation,
   input  logic [TASK_W-1:0]     req_task_id,
   input  logic [MSG_PORT_W-1:0] req_message,
   // register write
   input  logic                  csr_write,
   input  logic [CAP_W-1:0]      csr_data,
   // control
   input  cmd_type               cmd,
   output status_type            status,
   // response
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output result_kind_type       rsp_kind,
   output logic [TASK_W-1:0]     rsp_task,
   output logic [MSG_PORT_W-1:0] rsp_message,
   output logic                  rsp_last
);

   localparam int QAW   = $clog2(QUEUE_DEPTH);
   localparam int QCW   = $clog2(QUEUE_DEPTH + 1);
   localparam int WAW   = (WAITER_DEPTH > 1) ? $clog2(WAITER_DEPTH) : 1;
   localparam int WCW   = $clog2(WAITER_DEPTH + 1);
   localparam int MSG_W = (MESSAGE_BITS < MSG_PORT_W) ? MESSAGE_BITS : MSG_PORT_W;
   localparam int PW    = (QAW + 1 > QCW) ? QAW + 1 : QCW;
   localparam int PRW   = MSG_W + TASK_W;

   // Captured request
   op_type             op_ff;
   logic [TASK_W-1:0]  task_ff;
   logic [MSG_W-1:0]   msg_ff;

   // Queue state
   logic [CAP_W-1:0]   cap_ff;
   logic [QAW-1:0]     rp_ff, rp_in;
   logic [QAW-1:0]     wp_ff, wp_in;
   logic [QCW-1:0]     fill_ff, fill_in;
   logic [WCW-1:0]     pcnt_ff, pcnt_in;
   logic [WCW-1:0]     ccnt_ff, ccnt_in;
   logic [TASK_W-1:0]  wake_task_ff, wake_task_in;

   // Response register
   logic                  rsp_valid_ff;
   result_kind_type       rsp_kind_ff;
   logic [TASK_W-1:0]     rsp_task_ff;
   logic [MSG_PORT_W-1:0] rsp_msg_ff;
   logic                  rsp_last_ff;

   // Decision of the current request
   result_kind_type    kind_in;
   logic [TASK_W-1:0]  res_task_in;
   logic [MSG_W-1:0]   res_msg_in;
   logic               two_in;

   // Memory ports
   logic               ring_we;
   logic [MSG_W-1:0]   ring_wdata;
   logic [MSG_W-1:0]   ring_rdata;
   logic               prod_we;
   logic [PRW-1:0]     prod_rdata;
   logic               cons_we;
   logic [TASK_W-1:0]  cons_rdata;
   logic [WCW-1:0]     pcnt_dec, ccnt_dec;

   logic [QCW-1:0]     cap_use;
   logic               out_free;

   // Step a ring pointer, wrapping at the last slot in use
   function automatic logic [QAW-1:0] advance(input logic [QAW-1:0] ptr,
                                              input logic [QCW-1:0] cap);
      logic [PW-1:0] nxt;
      nxt = PW'(ptr) + PW'(1);
      if (nxt >= PW'(cap)) return '0;
      return nxt[QAW-1:0];
   endfunction

   // Clamp the capacity register to between one slot and the built depth
   always_comb begin
      if (cap_ff == '0) begin
         cap_use = QCW'(1);
      end else if (int'(cap_ff) > QUEUE_DEPTH) begin
         cap_use = QCW'(QUEUE_DEPTH);
      end else begin
         cap_use = QCW'(cap_ff);
      end
   end

   assign pcnt_dec = pcnt_ff - WCW'(1);
   assign ccnt_dec = ccnt_ff - WCW'(1);

   // Stores: read addresses follow the live pointers so the registered read data is ready in the execute step
   bmq_ram #(.WIDTH(MSG_W), .DEPTH(QUEUE_DEPTH)) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (ring_wdata),
      .rd_addr (rp_ff),
      .rd_data (ring_rdata)
   );

   bmq_ram #(.WIDTH(PRW), .DEPTH(WAITER_DEPTH)) u_producers (
      .clock   (clock),
      .wr_en   (prod_we),
      .wr_addr (pcnt_ff[WAW-1:0]),
      .wr_data ({task_ff, msg_ff}),
      .rd_addr (pcnt_dec[WAW-1:0]),
      .rd_data (prod_rdata)
   );

   bmq_ram #(.WIDTH(TASK_W), .DEPTH(WAITER_DEPTH)) u_consumers (
      .clock   (clock),
      .wr_en   (cons_we),
      .wr_addr (ccnt_ff[WAW-1:0]),
      .wr_data (task_ff),
      .rd_addr (ccnt_dec[WAW-1:0]),
      .rd_data (cons_rdata)
   );

   // Decide the request's results and the next queue state
   always_comb begin
      kind_in      = KIND_STORED;
      res_task_in  = task_ff;
      res_msg_in   = '0;
      two_in       = 1'b0;
      wake_task_in = wake_task_ff;
      rp_in        = rp_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      pcnt_in      = pcnt_ff;
      ccnt_in      = ccnt_ff;
      ring_we      = 1'b0;
      ring_wdata   = msg_ff;
      prod_we      = 1'b0;
      cons_we      = 1'b0;
      case (op_ff)
         OP_SEND: begin
            if (ccnt_ff != '0) begin
               // hand straight to the newest waiting consumer
               kind_in      = KIND_DELIVERED;
               res_task_in  = cons_rdata;
               res_msg_in   = msg_ff;
               two_in       = 1'b1;
               wake_task_in = cons_rdata;
               ccnt_in      = ccnt_dec;
            end else if (fill_ff >= cap_use) begin
               if (pcnt_ff != WCW'(WAITER_DEPTH)) begin
                  kind_in = KIND_BLOCKED;
                  prod_we = cmd.commit;
                  pcnt_in = pcnt_ff + WCW'(1);
               end else begin
                  kind_in = KIND_REJECTED;
               end
            end else begin
               kind_in = KIND_STORED;
               ring_we = cmd.commit;
               wp_in   = advance(wp_ff, cap_use);
               fill_in = fill_ff + QCW'(1);
            end
         end
         OP_RECEIVE: begin
            if (fill_ff != '0) begin
               kind_in    = KIND_DELIVERED;
               res_msg_in = ring_rdata;
               rp_in      = advance(rp_ff, cap_use);
               if (pcnt_ff != '0) begin
                  // refill the freed slot from the newest waiting producer
                  two_in       = 1'b1;
                  wake_task_in = prod_rdata[MSG_W +: TASK_W];
                  pcnt_in      = pcnt_dec;
                  ring_we      = cmd.commit;
                  ring_wdata   = prod_rdata[MSG_W-1:0];
                  wp_in        = advance(wp_ff, cap_use);
               end else begin
                  fill_in = fill_ff - QCW'(1);
               end
            end else if (ccnt_ff != WCW'(WAITER_DEPTH)) begin
               kind_in = KIND_BLOCKED;
               cons_we = cmd.commit;
               ccnt_in = ccnt_ff + WCW'(1);
            end else begin
               kind_in = KIND_REJECTED;
            end
         end
         default: begin
            kind_in = KIND_REJECTED;
         end
      endcase
   end

   // Capture the request payload
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= req_operation;
         task_ff <= req_task_id;
         msg_ff  <= req_message[MSG_W-1:0];
      end
   end

   // Queue state: advance on commit, capacity on register write
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff  <= CAP_RESET;
         rp_ff   <= '0;
         wp_ff   <= '0;
         fill_ff <= '0;
         pcnt_ff <= '0;
         ccnt_ff <= '0;
      end else begin
         if (csr_write) cap_ff <= csr_data;
         if (cmd.commit) begin
            rp_ff   <= rp_in;
            wp_ff   <= wp_in;
            fill_ff <= fill_in;
            pcnt_ff <= pcnt_in;
            ccnt_ff <= ccnt_in;
         end
      end
   end

   // Hold the task to wake for the second result
   always_ff @(posedge clock) begin
      if (cmd.commit) wake_task_ff <= wake_task_in;
   end

   // Response register: load a result, drop it once taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit || cmd.load_second) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_kind_ff <= kind_in;
         rsp_task_ff <= res_task_in;
         rsp_msg_ff  <= MSG_PORT_W'(res_msg_in);
         rsp_last_ff <= !two_in;
      end else if (cmd.load_second) begin
         rsp_kind_ff <= KIND_WOKEN;
         rsp_task_ff <= wake_task_ff;
         rsp_msg_ff  <= '0;
         rsp_last_ff <= 1'b1;
      end
   end

   assign status.out_free    = out_free;
   assign status.two_results = two_in;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_kind    = rsp_kind_ff;
   assign rsp_task    = rsp_task_ff;
   assign rsp_message = rsp_msg_ff;
   assign rsp_last    = rsp_last_ff;

   // Checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= QCW'(QUEUE_DEPTH))
      else $error("ring fill count beyond built depth");

   a_wait_bound: assert property (@(posedge clock) disable iff (reset)
      (pcnt_ff <= WCW'(WAITER_DEPTH)) && (ccnt_ff <= WCW'(WAITER_DEPTH)))
      else $error("waiter count beyond stack depth");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit || cmd.load_second) |-> out_free)
      else $error("result loaded over an untaken response");

   a_refill_keeps_fill: assert property (@(posedge clock) disable iff (reset)
      (cmd.commit && op_ff == OP_RECEIVE && fill_ff != '0 && pcnt_ff != '0)
      |=> fill_ff == $past(fill_ff))
      else $error("producer refill changed the fill count");

endmodule

@@ rtl/blocking_message_queue_core.sv @@
// Top level of the blocking message queue: controller, datapath and channels.
// Depends on bmq_pkg, the bmq_*_if interfaces, bmq_ctrl and bmq_datapath.
//
//   channel   dir  handshake          payload
//   req_ch    in   valid / ready      operation, task_id, message
//   rsp_ch    out  valid / ready      result_kind, result_task, result_message, last_result
//   csr_ch    in   valid / ready      queue_capacity (always ready)
//
// A request with one result passes through accept, then execute with the
// registered store read data; one with two results adds a second-result step,
// as there is a single response register. Reset clears pointers, counts and the
// controller at once; the ring and waiter stores are not cleared. A stalled
// response holds the block in its execute or second-result step.
module blocking_message_queue_core import bmq_pkg::*; #(
   parameter int QUEUE_DEPTH  = DEF_QUEUE_DEPTH,
   parameter int WAITER_DEPTH = DEF_WAITER_DEPTH,
   parameter int MESSAGE_BITS = DEF_MESSAGE_BITS
) (
   input logic      clock,
   input logic      reset,
   bmq_req_if.sink  req_ch,
   bmq_rsp_if.source rsp_ch,
   bmq_csr_if.sink  csr_ch
);

   cmd_type    cmd;
   status_type status;

   // Capacity register accepts a write in any cycle
   assign csr_ch.ready = 1'b1;

   bmq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   bmq_datapath #(
      .QUEUE_DEPTH  (QUEUE_DEPTH),
      .WAITER_DEPTH (WAITER_DEPTH),
      .MESSAGE_BITS (MESSAGE_BITS)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_operation (req_ch.operation),
      .req_task_id   (req_ch.task_id),
      .req_message   (req_ch.message),
      .csr_write     (csr_ch.valid),
      .csr_data      (csr_ch.queue_capacity),
      .cmd           (cmd),
      .status        (status),
      .rsp_ready     (rsp_ch.ready),
      .rsp_valid     (rsp_ch.valid),
      .rsp_kind      (rsp_ch.result_kind),
      .rsp_task      (rsp_ch.result_task),
      .rsp_message   (rsp_ch.result_message),
      .rsp_last      (rsp_ch.last_result)
   );

endmodule

@@ tb/tb_blocking_message_queue_core.sv @@
`timescale 1ns / 1ps
// Testbench for blocking_message_queue_core: directed and random send/receive requests,
// each response checked against a behavioural predictor of the ring and waiter stacks.
// Depends on bmq_pkg, the bmq_req_if, bmq_rsp_if and bmq_csr_if interfaces and the RTL.
module tb_blocking_message_queue_core;
   import bmq_pkg::*;

   localparam int RING_SLOTS    = DEF_QUEUE_DEPTH;
   localparam int WAITER_SLOTS  = DEF_WAITER_DEPTH;
   localparam int SETTLE_CYCLES = 8;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int MAX_REPORTS   = 40;

   typedef struct {
      result_kind_type       kind;
      logic [TASK_W-1:0]     owner;
      logic [MSG_PORT_W-1:0] word;
      logic                  last_flag;
   } outcome_type;

   logic clock;
   logic reset;

   bmq_req_if request_bus ();
   bmq_rsp_if response_bus ();
   bmq_csr_if capacity_bus ();

   blocking_message_queue_core DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (request_bus),
      .rsp_ch (response_bus),
      .csr_ch (capacity_bus)
   );

   // Predicted state of the queue
   logic [MSG_PORT_W-1:0] ring_word [RING_SLOTS];
   bit                    ring_written [RING_SLOTS];
   int unsigned           head_slot = 0;
   int unsigned           tail_slot = 0;
   int unsigned           held_count = 0;
   logic [TASK_W-1:0]     producer_owner [WAITER_SLOTS];
   logic [MSG_PORT_W-1:0] producer_word [WAITER_SLOTS];
   int unsigned           producer_depth = 0;
   logic [TASK_W-1:0]     consumer_owner [WAITER_SLOTS];
   int unsigned           consumer_depth = 0;
   logic [CAP_W-1:0]      capacity_setting = CAP_RESET;

   outcome_type pending_outcomes [$];
   int          mismatch_count = 0;
   int          sender_idle_pct = 0;
   int          receiver_idle_pct = 0;

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard limit on run length
   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("Timeout after %0d cycles, %0d responses outstanding", CYCLE_LIMIT,
               pending_outcomes.size());
      $display("*** FAILED ***");
      $finish;
   end

   // Stall the response channel at random
   always @(posedge clock) begin
      response_bus.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Clamp the capacity register to the slots actually in use
   function automatic int unsigned slots_in_use();
      if (capacity_setting == 0) return 1;
      if (capacity_setting > RING_SLOTS) return RING_SLOTS;
      return capacity_setting;
   endfunction

   // Advance a ring pointer, wrapping at the last slot in use
   function automatic int unsigned next_slot(int unsigned slot);
      int unsigned n;
      n = slot + 1;
      if (n >= slots_in_use() || n >= RING_SLOTS) n = 0;
      return n;
   endfunction

   function automatic void put_in_ring(logic [MSG_PORT_W-1:0] word);
      ring_word[tail_slot]    = word;
      ring_written[tail_slot] = 1'b1;
      tail_slot               = next_slot(tail_slot);
      held_count++;
   endfunction

   function automatic void expect_outcome(result_kind_type kind, logic [TASK_W-1:0] owner,
                                          logic [MSG_PORT_W-1:0] word, logic last_flag);
      outcome_type item;
      item.kind      = kind;
      item.owner     = owner;
      item.word      = word;
      item.last_flag = last_flag;
      pending_outcomes.push_back(item);
   endfunction

   // A receive now would read a slot that has never held a message
   function automatic bit head_slot_unwritten();
      return held_count > 0 && !ring_written[head_slot];
   endfunction

   // Work out the responses to one accepted request and update the predicted state
   function automatic void apply_queue_request(op_type op, logic [TASK_W-1:0] requester,
                                               logic [MSG_PORT_W-1:0] word);
      logic [TASK_W-1:0]     waiter;
      logic [MSG_PORT_W-1:0] fetched;
      if (op == OP_SEND) begin
         if (consumer_depth > 0) begin
            // hand the message straight to the newest waiting consumer
            consumer_depth--;
            waiter = consumer_owner[consumer_depth];
            expect_outcome(KIND_DELIVERED, waiter, word, 1'b0);
            expect_outcome(KIND_WOKEN, waiter, '0, 1'b1);
         end else if (held_count >= slots_in_use()) begin
            if (producer_depth < WAITER_SLOTS) begin
               producer_owner[producer_depth] = requester;
               producer_word[producer_depth]  = word;
               producer_depth++;
               expect_outcome(KIND_BLOCKED, requester, '0, 1'b1);
            end else begin
               expect_outcome(KIND_REJECTED, requester, '0, 1'b1);
            end
         end else begin
            put_in_ring(word);
            expect_outcome(KIND_STORED, requester, '0, 1'b1);
         end
      end else begin
         if (held_count > 0) begin
            fetched   = ring_word[head_slot];
            head_slot = next_slot(head_slot);
            held_count--;
            if (producer_depth > 0) begin
               // refill the freed slot from the newest waiting producer
               producer_depth--;
               waiter = producer_owner[producer_depth];
               put_in_ring(producer_word[producer_depth]);
               expect_outcome(KIND_DELIVERED, requester, fetched, 1'b0);
               expect_outcome(KIND_WOKEN, waiter, '0, 1'b1);
            end else begin
               expect_outcome(KIND_DELIVERED, requester, fetched, 1'b1);
            end
         end else if (consumer_depth < WAITER_SLOTS) begin
            consumer_owner[consumer_depth] = requester;
            consumer_depth++;
            expect_outcome(KIND_BLOCKED, requester, '0, 1'b1);
         end else begin
            expect_outcome(KIND_REJECTED, requester, '0, 1'b1);
         end
      end
   endfunction

   task automatic report_mismatch(string text);
      if (mismatch_count < MAX_REPORTS) $display("%0t ns: mismatch: %s", $time, text);
      mismatch_count++;
   endtask

   // Compare each accepted response with the oldest prediction
   always @(posedge clock) begin : check_responses
      outcome_type due;
      if (!reset && response_bus.valid && response_bus.ready) begin
         if (pending_outcomes.size() == 0) begin
            report_mismatch($sformatf("unexpected response kind %0d task %0d",
                                      response_bus.result_kind, response_bus.result_task));
         end else begin
            due = pending_outcomes.pop_front();
            if (response_bus.result_kind !== due.kind)
               report_mismatch($sformatf("kind %0d, predicted %0d",
                                         response_bus.result_kind, due.kind));
            if (response_bus.result_task !== due.owner)
               report_mismatch($sformatf("task %0d, predicted %0d",
                                         response_bus.result_task, due.owner));
            if (response_bus.result_message !== due.word)
               report_mismatch($sformatf("message %h, predicted %h",
                                         response_bus.result_message, due.word));
            if (response_bus.last_result !== due.last_flag)
               report_mismatch($sformatf("last flag %b, predicted %b",
                                         response_bus.last_result, due.last_flag));
         end
      end
   end

   // Present one request and hold it until the block takes it
   task automatic send_request(op_type op, logic [TASK_W-1:0] requester,
                               logic [MSG_PORT_W-1:0] word);
      while ($urandom_range(99) < sender_idle_pct) begin
         request_bus.valid <= 1'b0;
         @(posedge clock);
      end
      request_bus.valid     <= 1'b1;
      request_bus.operation <= op;
      request_bus.task_id   <= requester;
      request_bus.message   <= word;
      @(posedge clock);
      while (!request_bus.ready) @(posedge clock);
      apply_queue_request(op, requester, word);
   endtask

   // Drop the request valid and wait for every predicted response
   task automatic drain_outcomes();
      request_bus.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write the capacity register once the block is idle
   task automatic write_capacity(logic [CAP_W-1:0] value);
      drain_outcomes();
      capacity_bus.valid          <= 1'b1;
      capacity_bus.queue_capacity <= value;
      @(posedge clock);
      while (!capacity_bus.ready) @(posedge clock);
      capacity_bus.valid <= 1'b0;
      capacity_setting = value;
   endtask

   // Store the extreme message words and read them back in order
   task automatic test_store_and_fetch();
      send_request(OP_SEND, 8'h00, 32'h0000_0000);
      send_request(OP_SEND, 8'hFF, 32'hFFFF_FFFF);
      send_request(OP_RECEIVE, 8'hA5, 32'h5A5A_5A5A);
      send_request(OP_RECEIVE, 8'h5A, 32'hA5A5_A5A5);
   endtask

   // Fill the consumer stack from an empty ring, overflow it, then hand messages over
   // until no consumer waits
   task automatic test_consumer_waiters();
      for (int k = 0; k < WAITER_SLOTS; k++)
         send_request(OP_RECEIVE, 8'(8'h10 + k), $urandom);
      send_request(OP_RECEIVE, 8'hEE, $urandom);
      send_request(OP_SEND, 8'h33, 32'hDEAD_BEEF);
      for (int k = 1; k < WAITER_SLOTS; k++)
         send_request(OP_SEND, 8'(8'h40 + k), $urandom);
   endtask

   // Shrink the ring below its fill, fill and overflow the producer stack, then refill
   task automatic test_producer_waiters_after_shrink();
      send_request(OP_SEND, 8'h01, 32'h1234_5678);
      send_request(OP_SEND, 8'h02, 32'h8765_4321);
      write_capacity(5'd1);
      for (int k = 0; k < WAITER_SLOTS; k++)
         send_request(OP_SEND, 8'(8'h80 + k), $urandom);
      send_request(OP_SEND, 8'hC3, $urandom);
      send_request(OP_RECEIVE, 8'h3C, $urandom);
   endtask

   // Random traffic in bursts that lean towards sends or receives
   task automatic test_random_traffic(int send_gap_pct, int receive_gap_pct,
                                      logic [CAP_W-1:0] capacity, int count);
      int     receive_pct;
      int     burst_left;
      op_type op;
      write_capacity(capacity);
      sender_idle_pct   = send_gap_pct;
      receiver_idle_pct = receive_gap_pct;
      receive_pct       = 50;
      burst_left        = 0;
      for (int k = 0; k < count; k++) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(40, 8);
            case ($urandom_range(2))
               0: receive_pct = 25;
               1: receive_pct = 50;
               default: receive_pct = 75;
            endcase
         end
         burst_left--;
         op = ($urandom_range(99) < receive_pct) ? OP_RECEIVE : OP_SEND;
         // never read a slot that has not been written since reset
         if (op == OP_RECEIVE && head_slot_unwritten()) op = OP_SEND;
         send_request(op, TASK_W'($urandom_range(255)), $urandom);
      end
   endtask

   initial begin
      reset                       <= 1'b1;
      request_bus.valid           <= 1'b0;
      request_bus.operation       <= OP_SEND;
      request_bus.task_id         <= '0;
      request_bus.message         <= '0;
      capacity_bus.valid          <= 1'b0;
      capacity_bus.queue_capacity <= CAP_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct   = 23;
      receiver_idle_pct = 57;
      test_store_and_fetch();
      test_consumer_waiters();
      test_producer_waiters_after_shrink();

      test_random_traffic(23, 57, 5'd2, 290);
      test_random_traffic(23, 57, 5'd16, 290);
      test_random_traffic(57, 23, 5'd0, 290);
      test_random_traffic(57, 23, 5'd31, 290);
      test_random_traffic(0, 0, 5'd1, 290);
      test_random_traffic(0, 0, CAP_W'($urandom_range(15, 3)), 290);
      drain_outcomes();

      if (mismatch_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
